// ===== sv/pot_pkg.sv =====
// pot_pkg: shared constants for the point-over-triangle normal core
// no dependencies; imported by the front, back, top-level and checker modules

package pot_pkg;

    // positions of the coordinate differences in the queue word
    localparam int DI_BX_AX  = 0;
    localparam int DI_BY_AY  = 1;
    localparam int DI_BZ_AZ  = 2;
    localparam int DI_CX_BX  = 3;
    localparam int DI_CY_BY  = 4;
    localparam int DI_CZ_BZ  = 5;
    localparam int DI_AX_CX  = 6;
    localparam int DI_AZ_CZ  = 7;
    localparam int DI_PX_BX  = 8;
    localparam int DI_PZ_BZ  = 9;
    localparam int DI_PX_CX  = 10;
    localparam int DI_PZ_CZ  = 11;
    localparam int DI_PX_AX  = 12;
    localparam int DI_PZ_AZ  = 13;
    localparam int NUM_DIFFS = 14;

    // scaled normal: 7 magnitude bits found one bit per stage
    localparam int Q_BITS    = 7;
    localparam int OUT_BITS  = 8;

    // 127^2 = 16129 = 2^14 - 2^8 + 1
    localparam int SCALE_SQ_SH_HI = 14;
    localparam int SCALE_SQ_SH_LO = 8;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

endpackage

// ===== sv/pot_queue.sv =====
// pot_queue: small register queue between the front and back parts
// no package dependencies

module pot_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_slot [0:DEPTH-1];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [AW:0]      r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== sv/pot_front.sv =====
// pot_front: input register stage that forms the coordinate differences
// depends on pot_pkg for the difference layout

module pot_front import pot_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COORD_BITS-1:0]      i_point_x,
    input  logic signed [COORD_BITS-1:0]      i_point_z,
    input  logic signed [COORD_BITS-1:0]      i_a_x,
    input  logic signed [COORD_BITS-1:0]      i_a_y,
    input  logic signed [COORD_BITS-1:0]      i_a_z,
    input  logic signed [COORD_BITS-1:0]      i_b_x,
    input  logic signed [COORD_BITS-1:0]      i_b_y,
    input  logic signed [COORD_BITS-1:0]      i_b_z,
    input  logic signed [COORD_BITS-1:0]      i_c_x,
    input  logic signed [COORD_BITS-1:0]      i_c_y,
    input  logic signed [COORD_BITS-1:0]      i_c_z,
    output logic                              o_push,
    input  logic                              i_full,
    output logic [NUM_DIFFS*(COORD_BITS+1)-1:0] o_data
);
    localparam int C = COORD_BITS;
    localparam int D = COORD_BITS + 1;

    logic                     r_valid;
    logic [NUM_DIFFS*D-1:0]   r_data;
    logic [NUM_DIFFS*D-1:0]   n_data;
    logic                     advance;

    function automatic logic [D-1:0] fdiff(input logic [C-1:0] a, input logic [C-1:0] b);
        fdiff = {a[C-1], a} - {b[C-1], b};
    endfunction

    // exact differences, one bit wider than the coordinates
    always_comb begin
        n_data = '0;
        n_data[DI_BX_AX*D +: D] = fdiff(i_b_x, i_a_x);
        n_data[DI_BY_AY*D +: D] = fdiff(i_b_y, i_a_y);
        n_data[DI_BZ_AZ*D +: D] = fdiff(i_b_z, i_a_z);
        n_data[DI_CX_BX*D +: D] = fdiff(i_c_x, i_b_x);
        n_data[DI_CY_BY*D +: D] = fdiff(i_c_y, i_b_y);
        n_data[DI_CZ_BZ*D +: D] = fdiff(i_c_z, i_b_z);
        n_data[DI_AX_CX*D +: D] = fdiff(i_a_x, i_c_x);
        n_data[DI_AZ_CZ*D +: D] = fdiff(i_a_z, i_c_z);
        n_data[DI_PX_BX*D +: D] = fdiff(i_point_x, i_b_x);
        n_data[DI_PZ_BZ*D +: D] = fdiff(i_point_z, i_b_z);
        n_data[DI_PX_CX*D +: D] = fdiff(i_point_x, i_c_x);
        n_data[DI_PZ_CZ*D +: D] = fdiff(i_point_z, i_c_z);
        n_data[DI_PX_AX*D +: D] = fdiff(i_point_x, i_a_x);
        n_data[DI_PZ_AZ*D +: D] = fdiff(i_point_z, i_a_z);
    end

    assign advance = !r_valid || !i_full;
    assign o_ready = advance;
    assign o_push  = r_valid && !i_full;
    assign o_data  = r_data;

    // valid bit of the front register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== sv/pot_back.sv =====
// pot_back: edge tests, face normal, exact scaling to length 127, output register
// depends on pot_pkg for the difference layout and scale constants

module pot_back import pot_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    output logic                                o_pop,
    input  logic [NUM_DIFFS*(COORD_BITS+1)-1:0] i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_inside_res,
    output logic signed [OUT_BITS-1:0]          o_normal_x,
    output logic signed [OUT_BITS-1:0]          o_normal_y,
    output logic signed [OUT_BITS-1:0]          o_normal_z
);
    localparam int D   = COORD_BITS + 1;   // difference width
    localparam int P   = 2 * D;            // product width
    localparam int NW  = 2 * D + 1;        // signed normal / edge width
    localparam int AW  = 2 * D;            // normal magnitude width
    localparam int K   = (AW + 1) / 2;     // low half of the magnitude split
    localparam int HW  = AW - K;           // high half
    localparam int SW  = 2 * AW;           // square width
    localparam int SSW = 2 * AW + 2;       // sum of three squares
    localparam int UW  = SSW + Q_BITS;     // s * q
    localparam int TW  = 2 * AW + 16;      // s * q^2 and 16129 * n^2
    localparam int NST = Q_BITS + 1;       // search stage slots
    localparam int NV  = 4 + NST;          // valid bits ahead of the output

    logic en;
    logic [NV-1:0] r_vld;

    logic signed [D-1:0] d [0:NUM_DIFFS-1];

    // stage 1 products
    logic signed [P-1:0] r_pa [0:5];
    logic signed [P-1:0] r_pb [0:5];
    // stage 2 magnitudes
    logic [AW-1:0] r_mag [0:2];
    logic          r_neg2 [0:2];
    logic          r_in2;
    // stage 3 partial squares
    logic [2*HW-1:0] r_hh [0:2];
    logic [AW-1:0]   r_hl [0:2];
    logic [2*K-1:0]  r_ll [0:2];
    logic            r_neg3 [0:2];
    logic            r_in3;
    // stage 4 squares
    logic [SW-1:0] r_sq [0:2];
    logic          r_neg4 [0:2];
    logic          r_in4;
    // scale search slots
    logic [SSW-1:0]    r_s  [0:NST-1];
    logic [TW-1:0]     r_r  [0:NST-1][0:2];
    logic [TW-1:0]     r_t  [0:NST-1][0:2];
    logic [UW-1:0]     r_u  [0:NST-1][0:2];
    logic [Q_BITS-1:0] r_q  [0:NST-1][0:2];
    logic              r_ng [0:NST-1][0:2];
    logic              r_in [0:NST-1];
    // output register
    logic                       r_o_valid;
    logic                       r_o_inside;
    logic signed [OUT_BITS-1:0] r_o_n [0:2];
    logic signed [OUT_BITS-1:0] n_o_n [0:2];

    // whole back pipeline moves unless the output is held
    assign en    = !r_o_valid || i_ready;
    assign o_pop = en && !i_empty;

    always_comb begin
        for (int i = 0; i < NUM_DIFFS; i++) begin
            d[i] = signed'(i_data[i*D +: D]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[NV-2:0], !i_empty};
            r_o_valid <= r_vld[NV-1];
        end
    end

    // stage 1: edge-function and cross-product terms
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa[0] <= d[DI_BZ_AZ] * d[DI_PX_BX];
            r_pb[0] <= d[DI_BX_AX] * d[DI_PZ_BZ];
            r_pa[1] <= d[DI_CX_BX] * d[DI_PZ_CZ];
            r_pb[1] <= d[DI_CZ_BZ] * d[DI_PX_CX];
            r_pa[2] <= d[DI_AX_CX] * d[DI_PZ_AZ];
            r_pb[2] <= d[DI_AZ_CZ] * d[DI_PX_AX];
            r_pa[3] <= d[DI_BY_AY] * d[DI_CZ_BZ];
            r_pb[3] <= d[DI_BZ_AZ] * d[DI_CY_BY];
            r_pa[4] <= d[DI_BZ_AZ] * d[DI_CX_BX];
            r_pb[4] <= d[DI_BX_AX] * d[DI_CZ_BZ];
            r_pa[5] <= d[DI_BX_AX] * d[DI_CY_BY];
            r_pb[5] <= d[DI_BY_AY] * d[DI_CX_BX];
        end
    end

    // stage 2: inclusive edge tests, normal components, magnitude and sign
    logic                 inside2;
    logic signed [NW-1:0] nrm [0:2];
    logic [NW-1:0]        absn [0:2];
    always_comb begin
        inside2 = (r_pa[0] >= r_pb[0]) && (r_pa[1] <= r_pb[1]) && (r_pa[2] <= r_pb[2]);
        for (int c = 0; c < 3; c++) begin
            nrm[c]  = {r_pa[c+3][P-1], r_pa[c+3]} - {r_pb[c+3][P-1], r_pb[c+3]};
            absn[c] = nrm[c][NW-1] ? NW'(-nrm[c]) : NW'(nrm[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in2 <= inside2;
            for (int c = 0; c < 3; c++) begin
                // outside points carry a zero normal
                r_mag[c]  <= inside2 ? absn[c][AW-1:0] : '0;
                r_neg2[c] <= nrm[c][NW-1];
            end
        end
    end

    // stage 3: split squares into half-width partial products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in3 <= r_in2;
            for (int c = 0; c < 3; c++) begin
                r_hh[c]   <= r_mag[c][AW-1:K] * r_mag[c][AW-1:K];
                r_hl[c]   <= r_mag[c][AW-1:K] * r_mag[c][K-1:0];
                r_ll[c]   <= r_mag[c][K-1:0] * r_mag[c][K-1:0];
                r_neg3[c] <= r_neg2[c];
            end
        end
    end

    // stage 4: recombine squares
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in4 <= r_in3;
            for (int c = 0; c < 3; c++) begin
                r_sq[c]   <= (SW'(r_hh[c]) << (2 * K)) + (SW'(r_hl[c]) << (K + 1))
                           + SW'(r_ll[c]);
                r_neg4[c] <= r_neg3[c];
            end
        end
    end

    // stage 5: squared length and 127^2 * n^2 bounds, search state cleared
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s[0]  <= SSW'(r_sq[0]) + SSW'(r_sq[1]) + SSW'(r_sq[2]);
            r_in[0] <= r_in4;
            for (int c = 0; c < 3; c++) begin
                r_r[0][c]  <= (TW'(r_sq[c]) << SCALE_SQ_SH_HI)
                            - (TW'(r_sq[c]) << SCALE_SQ_SH_LO) + TW'(r_sq[c]);
                r_t[0][c]  <= '0;
                r_u[0][c]  <= '0;
                r_q[0][c]  <= '0;
                r_ng[0][c] <= r_neg4[c];
            end
        end
    end

    // one quotient bit per stage: keep bit if s*(q+b)^2 <= 127^2 * n^2
    for (genvar j = 0; j < Q_BITS; j++) begin : g_iter
        localparam int KB = Q_BITS - 1 - j;
        logic [TW-1:0] cand [0:2];
        logic          take [0:2];

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                cand[c] = r_t[j][c] + (TW'(r_u[j][c]) << (KB + 1))
                        + (TW'(r_s[j]) << (2 * KB));
                take[c] = (cand[c] <= r_r[j][c]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s[j+1]  <= r_s[j];
                r_in[j+1] <= r_in[j];
                for (int c = 0; c < 3; c++) begin
                    r_r[j+1][c]  <= r_r[j][c];
                    r_ng[j+1][c] <= r_ng[j][c];
                    r_t[j+1][c]  <= take[c] ? cand[c] : r_t[j][c];
                    r_u[j+1][c]  <= take[c] ? r_u[j][c] + (UW'(r_s[j]) << KB) : r_u[j][c];
                    r_q[j+1][c]  <= take[c] ? (r_q[j][c] | Q_BITS'(1 << KB)) : r_q[j][c];
                end
            end
        end
    end

    // sign and zero-length handling
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_s[NST-1] == '0) begin
                n_o_n[c] = '0;
            end else if (r_ng[NST-1][c]) begin
                n_o_n[c] = -signed'({1'b0, r_q[NST-1][c]});
            end else begin
                n_o_n[c] = signed'({1'b0, r_q[NST-1][c]});
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_inside <= r_in[NST-1];
            for (int c = 0; c < 3; c++) begin
                r_o_n[c] <= n_o_n[c];
            end
        end
    end

    assign o_valid      = r_o_valid;
    assign o_inside_res = r_o_inside;
    assign o_normal_x   = r_o_n[0];
    assign o_normal_y   = r_o_n[1];
    assign o_normal_z   = r_o_n[2];

endmodule

// ===== sv/point_over_triangle_normal_core.sv =====
// throughput: one item per cycle while the output is not held; the 7-stage bit-by-bit scale
// search and the split squaring stages form a pipeline that can accept a new item every cycle
// a 4-entry queue after the difference stage lets input and output stall apart
// reset: synchronous, active low; clears valid bits, queue pointers and fill count only
// depends on pot_pkg, pot_front, pot_queue and pot_back

module point_over_triangle_normal_core import pot_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_BITS-1:0]  i_point_x,
    input  logic signed [COORD_BITS-1:0]  i_point_z,
    input  logic signed [COORD_BITS-1:0]  i_a_x,
    input  logic signed [COORD_BITS-1:0]  i_a_y,
    input  logic signed [COORD_BITS-1:0]  i_a_z,
    input  logic signed [COORD_BITS-1:0]  i_b_x,
    input  logic signed [COORD_BITS-1:0]  i_b_y,
    input  logic signed [COORD_BITS-1:0]  i_b_z,
    input  logic signed [COORD_BITS-1:0]  i_c_x,
    input  logic signed [COORD_BITS-1:0]  i_c_y,
    input  logic signed [COORD_BITS-1:0]  i_c_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_inside_res,
    output logic signed [OUT_BITS-1:0]    o_normal_x,
    output logic signed [OUT_BITS-1:0]    o_normal_y,
    output logic signed [OUT_BITS-1:0]    o_normal_z
);
    localparam int QW = NUM_DIFFS * (COORD_BITS + 1);

    logic          push, full, pop, empty;
    logic [QW-1:0] front_data, queue_data;

    // front: input register and differences
    pot_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_point_x (i_point_x),
        .i_point_z (i_point_z),
        .i_a_x     (i_a_x),
        .i_a_y     (i_a_y),
        .i_a_z     (i_a_z),
        .i_b_x     (i_b_x),
        .i_b_y     (i_b_y),
        .i_b_z     (i_b_z),
        .i_c_x     (i_c_x),
        .i_c_y     (i_c_y),
        .i_c_z     (i_c_z),
        .o_push    (push),
        .i_full    (full),
        .o_data    (front_data)
    );

    // decoupling queue
    pot_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (queue_data)
    );

    // back: tests, normal and scaling
    pot_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .o_pop        (pop),
        .i_data       (queue_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_inside_res (o_inside_res),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z)
    );

endmodule

// ===== sv/pot_checker.sv =====
// pot_checker: port-level assertions for point_over_triangle_normal_core
// depends on pot_pkg; bound to the top level at the end of this file

module pot_checker import pot_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic                       o_inside_res,
    input logic signed [OUT_BITS-1:0] o_normal_x,
    input logic signed [OUT_BITS-1:0] o_normal_y,
    input logic signed [OUT_BITS-1:0] o_normal_z
);
    localparam logic [OUT_BITS-1:0] MOST_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

    // a held result stays offered unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_normal_x)
            && $stable(o_normal_y) && $stable(o_normal_z) && $stable(o_inside_res))
        else $error("output changed while stalled");

    // outside points give a zero normal
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_inside_res |-> o_normal_x == '0 && o_normal_y == '0
            && o_normal_z == '0)
        else $error("nonzero normal for outside point");

    // scaled components stay within -127..127
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_normal_x != MOST_NEG && o_normal_y != MOST_NEG
            && o_normal_z != MOST_NEG)
        else $error("normal component out of range");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

endmodule

bind point_over_triangle_normal_core pot_checker u_pot_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_inside_res (o_inside_res),
    .o_normal_x   (o_normal_x),
    .o_normal_y   (o_normal_y),
    .o_normal_z   (o_normal_z)
);
